// ===== hdl/cwq_pkg.sv =====
// Shared types, constants and index helpers for the chunk write-back queue.
// Used by cwq_ctrl, cwq_dp and chunk_writeback_queue; no dependencies of its own.
package cwq_pkg;

    localparam int CHUNKS = 64;
    localparam int IDX_W  = $clog2(CHUNKS);
    localparam int CNT_W  = $clog2(CHUNKS + 1);
    localparam int ID_W   = 8;
    localparam int SEAL_W = 16;
    localparam int TIME_W = 32;
    localparam int ST_W   = 2;
    localparam int OUT_CNT_W = 9;

    typedef enum logic [2:0] {
        CMD_ADMIT   = 3'd0,
        CMD_BEGIN   = 3'd1,
        CMD_PERSIST = 3'd2,
        CMD_REQUEUE = 3'd3,
        CMD_FREE    = 3'd4,
        CMD_QUERY   = 3'd5
    } cmd_t;

    localparam logic [ST_W-1:0] ST_NONE      = 2'd0;
    localparam logic [ST_W-1:0] ST_QUEUED    = 2'd1;
    localparam logic [ST_W-1:0] ST_WRITING   = 2'd2;
    localparam logic [ST_W-1:0] ST_PERSISTED = 2'd3;

    typedef struct packed {
        logic [ST_W-1:0]   st;
        logic [SEAL_W-1:0] seal;
        logic [TIME_W-1:0] stamp;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOKUP,
        S_DECIDE,
        S_BW_RING,
        S_BW_CAND,
        S_BW_CHECK,
        S_SCAN,
        S_SCAN_END,
        S_FETCH,
        S_FINAL
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_LOOKUP,
        OP_DECIDE,
        OP_RING_RD,
        OP_CAND,
        OP_CHECK,
        OP_SCAN,
        OP_SCAN_END,
        OP_FETCH,
        OP_FINAL
    } dp_op_t;

    typedef struct packed {
        logic is_begin;
        logic ring_empty;
        logic cand_queued;
        logic scan_last;
        logic out_free;
    } dp_stat_t;

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
        idx_inc = (i == IDX_W'(CHUNKS - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
        idx_dec = (i == '0) ? IDX_W'(CHUNKS - 1) : i - 1'b1;
    endfunction

endpackage

// ===== hdl/cwq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No package dependency.
module cwq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/cwq_ctrl.sv =====
// Sequencer for the chunk write-back queue: walks each request through
// lookup, decision or begin-write ring pops, age scan and result load. Uses cwq_pkg.
module cwq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  cwq_pkg::dp_stat_t stat,
    output cwq_pkg::dp_op_t   op
);
    import cwq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:     if (req_valid) state_next = S_LOOKUP;
            S_LOOKUP:   state_next = stat.is_begin ? S_BW_RING : S_DECIDE;
            S_DECIDE:   state_next = S_SCAN;
            S_BW_RING:  state_next = stat.ring_empty ? S_SCAN : S_BW_CAND;
            S_BW_CAND:  state_next = S_BW_CHECK;
            // skip stale entries until a queued chunk turns up
            S_BW_CHECK: state_next = stat.cand_queued ? S_SCAN : S_BW_RING;
            S_SCAN:     if (stat.scan_last) state_next = S_SCAN_END;
            S_SCAN_END: state_next = S_FETCH;
            S_FETCH:    state_next = S_FINAL;
            S_FINAL:    if (stat.out_free) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        req_stall = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:     op = req_valid ? OP_LATCH : OP_NONE;
            S_LOOKUP:   op = OP_LOOKUP;
            S_DECIDE:   op = OP_DECIDE;
            S_BW_RING:  op = OP_RING_RD;
            S_BW_CAND:  op = OP_CAND;
            S_BW_CHECK: op = OP_CHECK;
            S_SCAN:     op = OP_SCAN;
            S_SCAN_END: op = OP_SCAN_END;
            S_FETCH:    op = OP_FETCH;
            S_FINAL:    op = OP_FINAL;
            default:    op = OP_NONE;
        endcase
    end

endmodule

// ===== hdl/cwq_dp.sv =====
// Datapath of the chunk write-back queue: chunk table and order ring RAMs,
// ring pointers, counters, age scan and result register. Uses cwq_pkg, cwq_ram.
module cwq_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  cwq_pkg::dp_op_t              op,
    output cwq_pkg::dp_stat_t            stat,
    input  logic [2:0]                   cmd,
    input  logic [cwq_pkg::ID_W-1:0]     chunk_id,
    input  logic                         is_sealed,
    input  logic [cwq_pkg::TIME_W-1:0]   now_ms,
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output logic                         ok,
    output logic [cwq_pkg::ID_W-1:0]     chunk_out,
    output logic [cwq_pkg::ST_W-1:0]     chunk_status,
    output logic [cwq_pkg::SEAL_W-1:0]   seal_number,
    output logic [cwq_pkg::OUT_CNT_W-1:0] queued_count,
    output logic [cwq_pkg::OUT_CNT_W-1:0] writing_count,
    output logic [cwq_pkg::TIME_W-1:0]   oldest_age
);
    import cwq_pkg::*;

    // request latch
    logic [2:0]        cmd_reg;
    logic [ID_W-1:0]   id_reg;
    logic              sealed_reg;
    logic [TIME_W-1:0] now_reg;

    logic [IDX_W-1:0]  head_reg, head_next;
    logic [IDX_W-1:0]  tail_reg, tail_next;
    logic [SEAL_W-1:0] seal_ctr_reg, seal_ctr_next;
    logic [CNT_W-1:0]  q_cnt_reg, q_cnt_next;
    logic [CNT_W-1:0]  w_cnt_reg, w_cnt_next;
    logic              ok_reg, ok_next;
    logic [ID_W-1:0]   cout_reg, cout_next;
    logic [IDX_W-1:0]  cand_reg;
    logic [IDX_W-1:0]  scan_idx_reg;
    logic              scan_pend_reg;
    logic [TIME_W-1:0] best_reg, best_next;
    logic [CHUNKS-1:0] vld_reg;
    logic              ent_vld_q;

    logic              rsp_valid_reg;
    logic              ok_out_reg;
    logic [ID_W-1:0]   cout_out_reg;
    logic [ST_W-1:0]   st_out_reg;
    logic [SEAL_W-1:0] seal_out_reg;
    logic [CNT_W-1:0]  q_out_reg;
    logic [CNT_W-1:0]  w_out_reg;
    logic [TIME_W-1:0] age_out_reg;

    // RAM ports
    logic               ent_we;
    logic [IDX_W-1:0]   ent_waddr;
    entry_t             ent_wdata;
    logic [IDX_W-1:0]   ent_raddr;
    logic [ENTRY_W-1:0] ent_rdata;
    entry_t             ent_q;
    logic               ring_we;
    logic [IDX_W-1:0]   ring_waddr;
    logic [IDX_W-1:0]   ring_wdata;
    logic [IDX_W-1:0]   ring_rdata;

    logic               id_ok;
    logic               cout_ok;
    logic [IDX_W-1:0]   id_idx;
    logic               ring_empty;
    logic               ring_full;
    logic               out_free;
    logic [TIME_W-1:0]  age;

    cwq_ram #(.WIDTH(ENTRY_W), .DEPTH(CHUNKS)) u_ent_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    cwq_ram #(.WIDTH(IDX_W), .DEPTH(CHUNKS)) u_ring_ram (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (ring_wdata),
        .raddr (head_reg),
        .rdata (ring_rdata)
    );

    assign ent_q      = ent_vld_q ? entry_t'(ent_rdata) : '0;
    assign id_ok      = ({1'b0, id_reg} < (ID_W + 1)'(CHUNKS));
    assign cout_ok    = ({1'b0, cout_reg} < (ID_W + 1)'(CHUNKS));
    assign id_idx     = id_reg[IDX_W-1:0];
    assign ring_empty = (head_reg == tail_reg);
    assign ring_full  = (idx_inc(tail_reg) == head_reg);
    assign out_free   = !rsp_valid_reg || !rsp_stall;
    assign age        = now_reg - ent_q.stamp;

    assign stat.is_begin    = (cmd_reg == CMD_BEGIN);
    assign stat.ring_empty  = ring_empty;
    assign stat.cand_queued = (ent_q.st == ST_QUEUED);
    assign stat.scan_last   = (scan_idx_reg == IDX_W'(CHUNKS - 1));
    assign stat.out_free    = out_free;

    always_comb
    begin
        case (op)
            OP_CAND:  ent_raddr = ring_rdata;
            OP_SCAN:  ent_raddr = scan_idx_reg;
            // keep reading the result chunk while the load waits
            OP_FETCH,
            OP_FINAL: ent_raddr = cout_reg[IDX_W-1:0];
            default:  ent_raddr = id_idx;
        endcase
    end

    always_comb
    begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        seal_ctr_next = seal_ctr_reg;
        q_cnt_next    = q_cnt_reg;
        w_cnt_next    = w_cnt_reg;
        ok_next       = ok_reg;
        cout_next     = cout_reg;
        best_next     = best_reg;
        ent_we        = 1'b0;
        ent_waddr     = id_idx;
        ent_wdata     = ent_q;
        ring_we       = 1'b0;
        ring_waddr    = tail_reg;
        ring_wdata    = id_idx;
        case (op)
            OP_DECIDE:
            begin
                case (cmd_reg)
                    CMD_ADMIT:
                    begin
                        if (id_ok && sealed_reg && ent_q.st == ST_NONE && !ring_full)
                        begin
                            ring_we         = 1'b1;
                            tail_next       = idx_inc(tail_reg);
                            ent_we          = 1'b1;
                            ent_wdata.st    = ST_QUEUED;
                            ent_wdata.seal  = seal_ctr_reg;
                            ent_wdata.stamp = now_reg;
                            seal_ctr_next   = seal_ctr_reg + 1'b1;
                            q_cnt_next      = q_cnt_reg + 1'b1;
                            ok_next         = 1'b1;
                        end
                    end
                    CMD_PERSIST:
                    begin
                        if (id_ok)
                        begin
                            ok_next = 1'b1;
                            if (ent_q.st == ST_WRITING)
                            begin
                                ent_we          = 1'b1;
                                ent_wdata.st    = ST_PERSISTED;
                                ent_wdata.stamp = '0;
                                w_cnt_next      = w_cnt_reg - 1'b1;
                            end
                        end
                    end
                    CMD_REQUEUE:
                    begin
                        if (id_ok && ent_q.st == ST_WRITING)
                        begin
                            // an empty ring takes the chunk at the tail
                            if (ring_empty)
                            begin
                                ring_we   = 1'b1;
                                tail_next = idx_inc(tail_reg);
                                ok_next   = 1'b1;
                            end
                            else if (idx_dec(head_reg) != tail_reg)
                            begin
                                ring_we    = 1'b1;
                                ring_waddr = idx_dec(head_reg);
                                head_next  = idx_dec(head_reg);
                                ok_next    = 1'b1;
                            end
                            if (ring_empty || idx_dec(head_reg) != tail_reg)
                            begin
                                ent_we       = 1'b1;
                                ent_wdata.st = ST_QUEUED;
                                q_cnt_next   = q_cnt_reg + 1'b1;
                                w_cnt_next   = w_cnt_reg - 1'b1;
                            end
                        end
                    end
                    CMD_FREE:
                    begin
                        if (id_ok)
                        begin
                            ok_next   = 1'b1;
                            ent_we    = 1'b1;
                            ent_wdata = '0;
                            if (ent_q.st == ST_QUEUED)
                            begin
                                q_cnt_next = q_cnt_reg - 1'b1;
                            end
                            if (ent_q.st == ST_WRITING)
                            begin
                                w_cnt_next = w_cnt_reg - 1'b1;
                            end
                        end
                    end
                    CMD_QUERY: ok_next = id_ok;
                    default:   ok_next = 1'b0;
                endcase
            end
            OP_CAND: head_next = idx_inc(head_reg);
            OP_CHECK:
            begin
                if (ent_q.st == ST_QUEUED)
                begin
                    ent_we       = 1'b1;
                    ent_waddr    = cand_reg;
                    ent_wdata.st = ST_WRITING;
                    q_cnt_next   = q_cnt_reg - 1'b1;
                    w_cnt_next   = w_cnt_reg + 1'b1;
                    ok_next      = 1'b1;
                    cout_next    = ID_W'(cand_reg);
                end
            end
            OP_SCAN, OP_SCAN_END:
            begin
                if (scan_pend_reg && ent_q.st == ST_QUEUED && ent_q.stamp != '0 &&
                    now_reg >= ent_q.stamp && age > best_reg)
                begin
                    best_next = age;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        ent_vld_q <= vld_reg[ent_raddr];
        if (op == OP_LATCH)
        begin
            cmd_reg    <= cmd;
            id_reg     <= chunk_id;
            sealed_reg <= is_sealed;
            now_reg    <= now_ms;
        end
        if (op == OP_CAND)
        begin
            cand_reg <= ring_rdata;
        end
        if (op == OP_FINAL && out_free)
        begin
            ok_out_reg   <= ok_reg;
            cout_out_reg <= cout_reg;
            st_out_reg   <= cout_ok ? ent_q.st : ST_NONE;
            seal_out_reg <= cout_ok ? ent_q.seal : '0;
            q_out_reg    <= q_cnt_reg;
            w_out_reg    <= w_cnt_reg;
            age_out_reg  <= best_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            seal_ctr_reg  <= SEAL_W'(1);
            q_cnt_reg     <= '0;
            w_cnt_reg     <= '0;
            ok_reg        <= 1'b0;
            cout_reg      <= '0;
            best_reg      <= '0;
            scan_idx_reg  <= '0;
            scan_pend_reg <= 1'b0;
            vld_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            seal_ctr_reg <= seal_ctr_next;
            q_cnt_reg    <= q_cnt_next;
            w_cnt_reg    <= w_cnt_next;
            if (ent_we)
            begin
                vld_reg[ent_waddr] <= 1'b1;
            end
            if (op == OP_LATCH)
            begin
                ok_reg        <= 1'b0;
                cout_reg      <= chunk_id;
                best_reg      <= '0;
                scan_idx_reg  <= '0;
                scan_pend_reg <= 1'b0;
            end
            else
            begin
                ok_reg   <= ok_next;
                cout_reg <= cout_next;
                best_reg <= best_next;
                if (op == OP_SCAN)
                begin
                    scan_idx_reg  <= idx_inc(scan_idx_reg);
                    scan_pend_reg <= 1'b1;
                end
                else if (op == OP_SCAN_END)
                begin
                    scan_pend_reg <= 1'b0;
                end
            end
            // hold the result until taken
            if (op == OP_FINAL && out_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign ok            = ok_out_reg;
    assign chunk_out     = cout_out_reg;
    assign chunk_status  = st_out_reg;
    assign seal_number   = seal_out_reg;
    assign queued_count  = OUT_CNT_W'(q_out_reg);
    assign writing_count = OUT_CNT_W'(w_out_reg);
    assign oldest_age    = age_out_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, q_cnt_reg} + {1'b0, w_cnt_reg}) <= (CNT_W + 1)'(CHUNKS))
        else $error("queued plus writing exceeds chunk count");

    a_load_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_FINAL && out_free) |=> rsp_valid_reg)
        else $error("result not presented after load");

    a_bw_count: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_CHECK && ent_q.st == ST_QUEUED) |=>
        (w_cnt_reg == $past(w_cnt_reg) + 1'b1))
        else $error("begin write did not raise writing count");

endmodule

// ===== hdl/chunk_writeback_queue.sv =====
// Chunk write-back scheduler, top level: sequencer plus datapath.
// Depends on cwq_pkg, cwq_ctrl, cwq_dp (which uses cwq_ram).
//
// Usage: one request (cmd, chunk_id, is_sealed, now_ms) is taken on the
// req channel when req_valid is high and req_stall low; exactly one result
// leaves on the rsp channel under rsp_valid / rsp_stall.
// The block works on one request at a time and holds req_stall high until
// the result is loaded into the output register; a result waiting there
// does not block the next request, only the load of the following result.
// Per request: table lookup and decision, an age scan over the chunk table
// (one entry per cycle from its single read port, then a scan-end step),
// then the final read of the result chunk and the load into the output
// register. Begin write replaces the decision by ring pops, each a ring
// read, a chunk table read of the candidate and a check, until a queued
// chunk turns up or the ring runs empty.
// Reset clears status, seal and stamp of every chunk through per-entry
// valid bits, empties the ring and sets the next seal number to one; no
// clearing pass is needed, requests are taken right after reset.
// While rsp_valid and rsp_stall are both high the result register holds its contents.
module chunk_writeback_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [2:0]                    cmd,
    input  logic [cwq_pkg::ID_W-1:0]      chunk_id,
    input  logic                          is_sealed,
    input  logic [cwq_pkg::TIME_W-1:0]    now_ms,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic                          ok,
    output logic [cwq_pkg::ID_W-1:0]      chunk_out,
    output logic [cwq_pkg::ST_W-1:0]      chunk_status,
    output logic [cwq_pkg::SEAL_W-1:0]    seal_number,
    output logic [cwq_pkg::OUT_CNT_W-1:0] queued_count,
    output logic [cwq_pkg::OUT_CNT_W-1:0] writing_count,
    output logic [cwq_pkg::TIME_W-1:0]    oldest_age
);
    import cwq_pkg::*;

    dp_op_t   op;
    dp_stat_t stat;

    cwq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .op        (op)
    );

    cwq_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .op            (op),
        .stat          (stat),
        .cmd           (cmd),
        .chunk_id      (chunk_id),
        .is_sealed     (is_sealed),
        .now_ms        (now_ms),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .ok            (ok),
        .chunk_out     (chunk_out),
        .chunk_status  (chunk_status),
        .seal_number   (seal_number),
        .queued_count  (queued_count),
        .writing_count (writing_count),
        .oldest_age    (oldest_age)
    );

endmodule
